/* rtl/rgb_to_hsl_converter_assert.svh */
// Assertion macros shared by the RGB to HSL converter modules.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef RGB_TO_HSL_CONVERTER_ASSERT_SVH
`define RGB_TO_HSL_CONVERTER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define RGB_HSL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgb_to_hsl_converter: same-cycle check failed");

`define RGB_HSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgb_to_hsl_converter: next-cycle check failed");

`else

`define RGB_HSL_ASSERT_IMP(label, ante, cons)

`define RGB_HSL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/rgb_hsl_pkg.sv */
// Shared types, constants and the divider step for the RGB to HSL converter.
// Has no dependencies; used by every module of the block.
package rgb_hsl_pkg;

    localparam int CH_W   = 8;
    localparam int SUM_W  = 9;
    localparam int DIV_W  = 11;
    localparam int REM_W  = 12;
    localparam int QUO_W  = 16;
    localparam int CELLS  = QUO_W;

    localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(510);
    localparam logic [SUM_W-1:0] CH_MAX  = SUM_W'(255);

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] dvs;
        logic [QUO_W-1:0] quo;
    } rgb_hsl_lane_t;

    typedef struct packed {
        rgb_hsl_lane_t hue;
        rgb_hsl_lane_t sat;
        rgb_hsl_lane_t light;
    } rgb_hsl_work_t;

    function automatic rgb_hsl_lane_t div_step(input rgb_hsl_lane_t lane);
        rgb_hsl_lane_t    res;
        logic             ge;
        logic [REM_W-1:0] diff;
        ge = (lane.rem >= REM_W'(lane.dvs));
        diff = ge ? (lane.rem - REM_W'(lane.dvs)) : lane.rem;
        res.rem = diff << 1;
        res.dvs = lane.dvs;
        res.quo = {lane.quo[QUO_W-2:0], ge};
        return res;
    endfunction

endpackage

/* rtl/rgb_hsl_prep.sv */
// Front stage: channel maximum and minimum, chroma, and numerator and divisor setup for hue, saturation and lightness.
// Depends on rgb_hsl_pkg for the lane types and widths.
module rgb_hsl_prep
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [31:0]                in_color,
    output logic                       out_valid,
    input  logic                       out_ready,
    output rgb_hsl_pkg::rgb_hsl_work_t out_work
);

    logic [rgb_hsl_pkg::CH_W-1:0]  red;
    logic [rgb_hsl_pkg::CH_W-1:0]  green;
    logic [rgb_hsl_pkg::CH_W-1:0]  blue;
    logic [rgb_hsl_pkg::CH_W-1:0]  mx;
    logic [rgb_hsl_pkg::CH_W-1:0]  mn;
    logic [rgb_hsl_pkg::CH_W-1:0]  chroma;
    logic [rgb_hsl_pkg::SUM_W-1:0] sum;
    logic [rgb_hsl_pkg::SUM_W-1:0] den_full;
    logic [rgb_hsl_pkg::CH_W-1:0]  den;
    logic [rgb_hsl_pkg::DIV_W-1:0] six_c;
    logic [rgb_hsl_pkg::DIV_W-1:0] num;
    rgb_hsl_pkg::rgb_hsl_work_t    work_next;
    rgb_hsl_pkg::rgb_hsl_work_t    work_reg;
    logic                          valid_reg;

    assign red   = in_color[31:24];
    assign green = in_color[23:16];
    assign blue  = in_color[15:8];

    always_comb
    begin
        mx = (red > green) ? red : green;
        mx = (mx > blue) ? mx : blue;
        mn = (red < green) ? red : green;
        mn = (mn < blue) ? mn : blue;
        chroma = mx - mn;
        sum = rgb_hsl_pkg::SUM_W'(mx) + rgb_hsl_pkg::SUM_W'(mn);
        six_c = (rgb_hsl_pkg::DIV_W'(chroma) << 2) + (rgb_hsl_pkg::DIV_W'(chroma) << 1);

        priority if (mx == red)
        begin
            num = (green >= blue)
                ? rgb_hsl_pkg::DIV_W'(green - blue)
                : rgb_hsl_pkg::DIV_W'(green) + six_c - rgb_hsl_pkg::DIV_W'(blue);
        end
        else if (mx == green)
        begin
            num = rgb_hsl_pkg::DIV_W'(blue) + (rgb_hsl_pkg::DIV_W'(chroma) << 1)
                - rgb_hsl_pkg::DIV_W'(red);
        end
        else
        begin
            num = rgb_hsl_pkg::DIV_W'(red) + (rgb_hsl_pkg::DIV_W'(chroma) << 2)
                - rgb_hsl_pkg::DIV_W'(green);
        end

        den_full = (sum <= rgb_hsl_pkg::CH_MAX) ? sum : (rgb_hsl_pkg::SUM_MAX - sum);
        den = den_full[rgb_hsl_pkg::CH_W-1:0];

        // A gray pixel or a black or white one divides zero by one.
        if (chroma == '0)
        begin
            work_next.hue.rem = '0;
            work_next.hue.dvs = rgb_hsl_pkg::DIV_W'(1);
        end
        else
        begin
            work_next.hue.rem = rgb_hsl_pkg::REM_W'(num) << 1;
            work_next.hue.dvs = six_c;
        end
        work_next.hue.quo = '0;

        if (den == '0)
        begin
            work_next.sat.rem = '0;
            work_next.sat.dvs = rgb_hsl_pkg::DIV_W'(1);
        end
        else
        begin
            work_next.sat.rem = rgb_hsl_pkg::REM_W'(chroma);
            work_next.sat.dvs = rgb_hsl_pkg::DIV_W'(den);
        end
        work_next.sat.quo = '0;

        work_next.light.rem = rgb_hsl_pkg::REM_W'(sum);
        work_next.light.dvs = rgb_hsl_pkg::DIV_W'(rgb_hsl_pkg::SUM_MAX);
        work_next.light.quo = '0;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            work_reg <= work_next;
        end
    end

endmodule

/* rtl/rgb_hsl_cell.sv */
// One divider cell: a single restoring step on the hue, saturation and lightness lanes.
// Depends on rgb_hsl_pkg for the lane types and the step function.
`include "rgb_to_hsl_converter_assert.svh"

module rgb_hsl_cell
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  rgb_hsl_pkg::rgb_hsl_work_t in_work,
    output logic                       out_valid,
    input  logic                       out_ready,
    output rgb_hsl_pkg::rgb_hsl_work_t out_work
);

    rgb_hsl_pkg::rgb_hsl_work_t     work_next;
    rgb_hsl_pkg::rgb_hsl_work_t     work_reg;
    logic                           valid_reg;
    logic [rgb_hsl_pkg::REM_W-1:0]  hue_bound;
    logic [rgb_hsl_pkg::REM_W-1:0]  sat_bound;

    always_comb
    begin
        work_next.hue   = rgb_hsl_pkg::div_step(in_work.hue);
        work_next.sat   = rgb_hsl_pkg::div_step(in_work.sat);
        work_next.light = rgb_hsl_pkg::div_step(in_work.light);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_work  = work_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            work_reg <= work_next;
        end
    end

    assign hue_bound = rgb_hsl_pkg::REM_W'(work_reg.hue.dvs) << 1;
    assign sat_bound = rgb_hsl_pkg::REM_W'(work_reg.sat.dvs) << 1;

    `RGB_HSL_ASSERT_IMP(a_hue_rem_bound, valid_reg, work_reg.hue.rem < hue_bound)
    `RGB_HSL_ASSERT_IMP(a_sat_rem_bound, valid_reg, work_reg.sat.rem < sat_bound)
    `RGB_HSL_ASSERT_NEXT(a_stage_holds, valid_reg && !out_ready, valid_reg)

endmodule

/* rtl/rgb_to_hsl_converter.sv */
// RGB to HSL converter built from a front stage, a chain of 16 divider cells
// (one quotient bit per cell for all three results) and an output register.
// Throughput is one pixel per clock while the output is not stalled.
// Each stage advances on its own, so bubbles close up behind a stalled output.
// rst_n clears all valid flags at once; payload registers are not reset.
// Depends on rgb_hsl_pkg, rgb_hsl_prep and rgb_hsl_cell.
`include "rgb_to_hsl_converter_assert.svh"

module rgb_to_hsl_converter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // color_word[31:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // hue_turn[15:0], saturation_frac[31:16], lightness_frac[47:32]
);

    rgb_hsl_pkg::rgb_hsl_work_t work_w  [0:rgb_hsl_pkg::CELLS];
    logic                       valid_w [0:rgb_hsl_pkg::CELLS];
    logic                       ready_w [0:rgb_hsl_pkg::CELLS];

    logic                                out_valid_reg;
    logic [rgb_hsl_pkg::QUO_W-1:0]       hue_reg;
    logic [rgb_hsl_pkg::QUO_W-1:0]       sat_reg;
    logic [rgb_hsl_pkg::QUO_W-1:0]       light_reg;
    logic                                out_load;

    rgb_hsl_prep u_prep
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_color  (s_tdata),
        .out_valid (valid_w[0]),
        .out_ready (ready_w[0]),
        .out_work  (work_w[0])
    );

    for (genvar i = 0; i < rgb_hsl_pkg::CELLS; i++)
    begin : g_cell
        rgb_hsl_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_w[i]),
            .in_ready  (ready_w[i]),
            .in_work   (work_w[i]),
            .out_valid (valid_w[i+1]),
            .out_ready (ready_w[i+1]),
            .out_work  (work_w[i+1])
        );
    end

    assign out_load = !out_valid_reg || m_tready;
    assign ready_w[rgb_hsl_pkg::CELLS] = out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= valid_w[rgb_hsl_pkg::CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && valid_w[rgb_hsl_pkg::CELLS])
        begin
            hue_reg   <= work_w[rgb_hsl_pkg::CELLS].hue.quo;
            sat_reg   <= work_w[rgb_hsl_pkg::CELLS].sat.quo;
            light_reg <= work_w[rgb_hsl_pkg::CELLS].light.quo;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {light_reg, sat_reg, hue_reg};

    `RGB_HSL_ASSERT_IMP(a_sat_range, out_valid_reg, sat_reg <= 16'd32768)
    `RGB_HSL_ASSERT_IMP(a_light_range, out_valid_reg, light_reg <= 16'd32768)
    `RGB_HSL_ASSERT_IMP(a_black_pixel, out_valid_reg && (light_reg == '0),
                        (sat_reg == '0) && (hue_reg == '0))

endmodule
